// ===== sv/sbph_pkg.sv =====
// Shared types, constants and register codes for the spectrum bar peak-hold meter.
package sbph_pkg;

  localparam int BANDS_DEF = 14;

  localparam int BAND_W  = 4;
  localparam int WORD_W  = 16;
  localparam int LEVEL_W = 6;
  localparam int GAIN_W  = 3;
  localparam int HOLD_W  = 8;
  localparam int CFG_W   = 8;
  // Bar and peak are worked at the width of a full 6 x 3 bit product.
  localparam int WIDE_W  = LEVEL_W + GAIN_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 6'd63;
  localparam logic [LEVEL_W-1:0] PEAK_RESET   = 6'd60;
  localparam logic [HOLD_W-1:0]  HOLD_RESET   = 8'd1;
  localparam logic [GAIN_W-1:0]  GAIN_RESET   = 3'd3;
  localparam logic [HOLD_W-1:0]  RELOAD_RESET = 8'd1;

  typedef enum logic {
    REG_LEVEL_GAIN       = 1'b0,
    REG_PEAK_HOLD_RELOAD = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [BAND_W-1:0] band_index;
    logic [WORD_W-1:0] spectrum_word;
  } sample_t;

  typedef struct packed {
    logic [BAND_W-1:0]  out_band;
    logic [LEVEL_W-1:0] bar_level;
    logic [LEVEL_W-1:0] peak_level;
  } meter_t;

  // One memory word per band.
  typedef struct packed {
    logic [LEVEL_W-1:0] bar;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold;
  } band_entry_t;

  localparam int ENTRY_W = $bits(band_entry_t);

  localparam band_entry_t ENTRY_RESET = '{bar: '0, peak: PEAK_RESET, hold: HOLD_RESET};

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [HOLD_W-1:0] reload;
  } meter_cfg_t;

endpackage

// ===== sv/sbph_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sbph_update.sv =====
// Per-band bar rise/fall and peak hold/decay update.
module sbph_update (
  input  sbph_pkg::band_entry_t          cur,
  input  logic [sbph_pkg::LEVEL_W-1:0]   mag,
  input  sbph_pkg::meter_cfg_t           cfg,
  output sbph_pkg::band_entry_t          upd
);
  import sbph_pkg::*;

  logic [WIDE_W-1:0] target;
  logic [WIDE_W-1:0] bar_w;
  logic [WIDE_W-1:0] peak_w;
  logic [HOLD_W-1:0] hold_w;

  always_comb begin
    target = WIDE_W'(mag) * WIDE_W'(cfg.gain);
    bar_w  = WIDE_W'(cur.bar);
    peak_w = WIDE_W'(cur.peak);
    hold_w = cur.hold;

    // Bar jumps up to the target, otherwise falls by one.
    if (bar_w < target) begin
      bar_w = target;
    end else if (bar_w != '0) begin
      bar_w = bar_w - WIDE_W'(1);
    end

    // New peak (unclamped bar) reloads the hold counter.
    if (bar_w > peak_w) begin
      peak_w = bar_w;
      hold_w = cfg.reload;
    end

    if (hold_w != '0) begin
      hold_w = hold_w - HOLD_W'(1);
    end else if (peak_w != '0) begin
      peak_w = peak_w - WIDE_W'(1);
    end

    upd.bar  = (bar_w > WIDE_W'(LEVEL_MAX)) ? LEVEL_MAX : bar_w[LEVEL_W-1:0];
    upd.peak = (peak_w > WIDE_W'(LEVEL_MAX)) ? LEVEL_MAX : peak_w[LEVEL_W-1:0];
    upd.hold = hold_w;
  end

endmodule

// ===== sv/spectrum_bar_peak_hold.sv =====
// Top level of the spectrum bar meter with fall-off and peak hold.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   sample   | sample_valid / sample_stall| band_index, spectrum_word
//   meter    | meter_valid  / meter_stall | out_band, bar_level, peak_level
//   config   | cfg_write                  | cfg_index, cfg_data
//
// One transaction per cycle sustained while meter_stall is low; meter_valid
// follows sample acceptance through the s1_valid and meter registers. The
// accept edge launches the band memory read, the update stage then updates
// the entry and, as it fires, writes it back and loads the output register.
// A back-to-back hit on the same band is forwarded around the memory. Reset
// is synchronous: per-band valid flops make all bands read as their reset
// values at once, so there is no clearing pass. A stalled meter register
// stalls the update stage, and sample_stall rises only while both are full.
module spectrum_bar_peak_hold #(
  parameter int BANDS = sbph_pkg::BANDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  sbph_pkg::sample_t           sample,
  output logic                        meter_valid,
  input  logic                        meter_stall,
  output sbph_pkg::meter_t            meter,
  input  logic                        cfg_write,
  input  sbph_pkg::reg_index_t        cfg_index,
  input  logic [sbph_pkg::CFG_W-1:0]  cfg_data
);
  import sbph_pkg::*;

  localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;
  // Range check is done wide enough to hold BANDS itself.
  localparam int CW = (AW > BAND_W) ? AW + 1 : BAND_W + 1;

  meter_cfg_t   cfg;

  // Update stage.
  logic              s1_valid;
  logic [BAND_W-1:0] s1_band;
  logic [AW-1:0]     s1_addr;
  logic              s1_inrange;
  logic [LEVEL_W-1:0] s1_mag;
  logic              fwd_hit;
  band_entry_t       fwd_data;

  logic [BANDS-1:0]  vld;
  band_entry_t       ram_q;
  band_entry_t       cur;
  band_entry_t       upd;

  logic              sample_accept;
  logic              s1_adv;
  logic              s1_fire;
  logic              wr_en;
  logic              in_range;
  logic [AW-1:0]     in_addr;

  // Update stage moves on whenever the meter register is free or draining.
  assign s1_adv        = !meter_valid || !meter_stall;
  assign sample_stall  = s1_valid && !s1_adv;
  assign sample_accept = sample_valid && !sample_stall;
  assign s1_fire       = s1_valid && s1_adv;
  assign wr_en         = s1_fire && s1_inrange;
  assign in_addr       = AW'(sample.band_index);
  assign in_range      = CW'(sample.band_index) < CW'(BANDS);

  sbph_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BANDS)
  ) u_band_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (upd),
    .re    (sample_accept),
    .raddr (in_addr),
    .rdata (ram_q)
  );

  // Forwarded value wins over the stale read; unwritten bands read as reset.
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (vld[s1_addr]) begin
      cur = ram_q;
    end else begin
      cur = ENTRY_RESET;
    end
  end

  sbph_update u_update (
    .cur (cur),
    .mag (s1_mag),
    .cfg (cfg),
    .upd (upd)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      meter_valid <= 1'b0;
      cfg.gain    <= GAIN_RESET;
      cfg.reload  <= RELOAD_RESET;
      vld         <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LEVEL_GAIN:       cfg.gain   <= cfg_data[GAIN_W-1:0];
          REG_PEAK_HOLD_RELOAD: cfg.reload <= cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (!sample_stall) begin
        s1_valid <= sample_valid;
      end
      if (s1_adv) begin
        meter_valid <= s1_valid;
      end
      if (wr_en) begin
        vld[s1_addr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (sample_accept) begin
      s1_band    <= sample.band_index;
      s1_addr    <= in_addr;
      s1_inrange <= in_range;
      s1_mag     <= sample.spectrum_word[LEVEL_W-1:0];
      // Same band written back at this edge: the memory read is stale.
      fwd_hit    <= wr_en && (s1_band == sample.band_index);
      fwd_data   <= upd;
    end
    if (s1_fire) begin
      meter.out_band   <= s1_band;
      meter.bar_level  <= s1_inrange ? upd.bar  : '0;
      meter.peak_level <= s1_inrange ? upd.peak : '0;
    end
  end

endmodule
